### sv/lcaa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the lowest living common ancestor engine.
package lcaa_pkg;

   localparam int NODE_W = 10;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_KILL  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;

   localparam logic [NODE_W-1:0] ROOT_NODE = 10'd1;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] result_node;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_KILL,
      OP_QUERY,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
   } entry_type;

endpackage

### sv/lcaa_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
module lcaa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lcaa_front.sv
`timescale 1ns / 1ps
// Front end: accepts request transactions, decodes the command and queues them.
module lcaa_front
   import lcaa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   output logic      q_valid,
   input  logic      q_pop,
   output entry_type q_head
);

   entry_type ent_ff [2];
   logic      wr_ptr_ff;
   logic      rd_ptr_ff;
   logic [1:0] count_ff;
   logic      push;
   entry_type new_ent;

   always_comb begin
      new_ent.node_a = req_data.first_node;
      new_ent.node_b = req_data.second_node;
      unique case (req_data.command)
         CMD_ADD:   new_ent.op = OP_ADD;
         CMD_KILL:  new_ent.op = OP_KILL;
         CMD_QUERY: new_ent.op = OP_QUERY;
         default:   new_ent.op = OP_NONE;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = ent_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_ent;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

### sv/lcaa_back.sv
`timescale 1ns / 1ps
// Back end: sequencer over the ancestor, depth, dead-flag and alive-pointer memories.
module lcaa_back
   import lcaa_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   output logic      q_pop,
   input  entry_type q_head,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int NW  = $clog2(NODES);
   localparam int LVW = $clog2(LEVELS);
   localparam int CW  = ((LEVELS > NODE_W) ? LEVELS : NODE_W) + 1;
   localparam logic [LVW-1:0] TOP_LV = LVW'(LEVELS - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_A_DEP, S_A_RD, S_A_WR,
      S_Q_DA, S_Q_DB, S_L_TST, S_L_UP, S_L_EQ,
      S_L2_RD, S_L2_A, S_L2_B, S_L2_F, S_V_RD, S_V_CHK, S_OUT
   } state_type;

   state_type         state_ff;
   entry_type         item_ff;
   logic [NODE_W-1:0] cnt_ff, new_ff, cur_ff, a_ff, b_ff, da_ff, db_ff, ta_ff, tgt_ff;
   logic [LVW-1:0]    lv_ff;
   logic [NODE_W-1:0] res_ff;
   logic [STAT_W-1:0] st_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic              anc_root_ff, dep_root_ff, dead_root_ff;

   logic              anc_we, dep_we, dead_we, alive_we;
   logic [NW-1:0]     anc_wn, anc_rn, dep_wa, dep_ra, dead_wa, dead_ra, alive_wa, alive_ra;
   logic [LVW-1:0]    anc_wl, anc_rl;
   logic [NODE_W-1:0] anc_wd, dep_wd, alive_wd;
   logic              dead_wd;
   logic [NODE_W-1:0] anc_rdata, dep_rdata, alive_rdata;
   logic              dead_rdata;
   logic [NODE_W-1:0] anc_q, dep_q;
   logic              dead_q;
   logic [NODE_W-1:0] rd_anc_node, rd_dep_node, rd_dead_node;
   logic              valid_a, valid_b, add_ok, step_ok;
   logic [NODE_W-1:0] a_next;

   function automatic logic node_ok(input logic [NODE_W-1:0] n, input logic [NODE_W-1:0] c);
      return (n >= ROOT_NODE) && (n <= c) && (32'(n) < NODES);
   endfunction

   assign valid_a = node_ok(item_ff.node_a, cnt_ff);
   assign valid_b = node_ok(item_ff.node_b, cnt_ff);
   assign add_ok  = valid_a && (32'(cnt_ff) + 1 < NODES);
   assign step_ok = CW'(db_ff) >= (CW'(1) << lv_ff) + CW'(da_ff);
   assign a_next  = (ta_ff != anc_q) ? ta_ff : a_ff;

   assign anc_q  = anc_root_ff ? ROOT_NODE : anc_rdata;
   assign dep_q  = dep_root_ff ? ROOT_NODE : dep_rdata;
   assign dead_q = dead_root_ff ? 1'b0 : dead_rdata;

   always_comb begin
      anc_we = 1'b0; anc_wn = '0; anc_wl = '0; anc_wd = '0;
      dep_we = 1'b0; dep_wa = '0; dep_wd = '0;
      dead_we = 1'b0; dead_wa = '0; dead_wd = 1'b0;
      alive_we = 1'b0; alive_wa = '0; alive_wd = '0;
      rd_anc_node = '0; anc_rl = '0;
      rd_dep_node = '0; rd_dead_node = '0;
      unique case (state_ff)
         S_DISP: begin
            if (item_ff.op == OP_ADD && add_ok) begin
               anc_we   = 1'b1; anc_wn = NW'(cnt_ff + 1'b1); anc_wd = item_ff.node_a;
               alive_we = 1'b1; alive_wa = NW'(cnt_ff + 1'b1); alive_wd = item_ff.node_a;
               dead_we  = 1'b1; dead_wa = NW'(cnt_ff + 1'b1);
            end
            if (item_ff.op == OP_KILL && valid_a && item_ff.node_a != ROOT_NODE) begin
               dead_we = 1'b1; dead_wa = NW'(item_ff.node_a); dead_wd = 1'b1;
            end
            rd_dep_node = item_ff.node_a;
         end
         S_A_DEP: begin
            dep_we = 1'b1; dep_wa = NW'(new_ff); dep_wd = dep_q + 1'b1;
         end
         S_A_RD: begin
            rd_anc_node = cur_ff; anc_rl = lv_ff - 1'b1;
         end
         S_A_WR: begin
            anc_we = 1'b1; anc_wn = NW'(new_ff); anc_wl = lv_ff; anc_wd = anc_q;
         end
         S_Q_DA:  rd_dep_node = item_ff.node_b;
         S_L_TST: begin
            rd_anc_node = b_ff; anc_rl = lv_ff;
         end
         S_L2_RD: begin
            rd_anc_node = a_ff; anc_rl = lv_ff;
         end
         S_L2_A: begin
            rd_anc_node = b_ff; anc_rl = lv_ff;
         end
         S_L2_B:  rd_anc_node = a_next;
         S_V_RD:  rd_dead_node = tgt_ff;
         default: ;
      endcase
      anc_rn   = NW'(rd_anc_node);
      dep_ra   = NW'(rd_dep_node);
      dead_ra  = NW'(rd_dead_node);
      alive_ra = NW'(rd_dead_node);
   end

   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      anc_root_ff  <= (rd_anc_node == ROOT_NODE);
      dep_root_ff  <= (rd_dep_node == ROOT_NODE);
      dead_root_ff <= (rd_dead_node == ROOT_NODE);
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= ROOT_NODE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_head;
                  state_ff <= S_DISP;
               end
            end
            S_DISP: begin
               a_ff <= item_ff.node_a;
               b_ff <= item_ff.node_b;
               unique case (item_ff.op)
                  OP_ADD: begin
                     if (!valid_a) begin
                        res_ff   <= '0;
                        st_ff    <= STAT_UNKNOWN;
                        state_ff <= S_OUT;
                     end else if (!add_ok) begin
                        res_ff   <= '0;
                        st_ff    <= STAT_FULL;
                        state_ff <= S_OUT;
                     end else begin
                        cnt_ff   <= cnt_ff + 1'b1;
                        new_ff   <= cnt_ff + 1'b1;
                        res_ff   <= cnt_ff + 1'b1;
                        st_ff    <= STAT_OK;
                        cur_ff   <= item_ff.node_a;
                        lv_ff    <= LVW'(1);
                        state_ff <= S_A_DEP;
                     end
                  end
                  OP_KILL: begin
                     res_ff   <= '0;
                     st_ff    <= (!valid_a || item_ff.node_a == ROOT_NODE) ?
                                 STAT_UNKNOWN : STAT_OK;
                     state_ff <= S_OUT;
                  end
                  OP_QUERY: begin
                     res_ff <= '0;
                     if (!valid_a || !valid_b) begin
                        st_ff    <= STAT_UNKNOWN;
                        state_ff <= S_OUT;
                     end else begin
                        st_ff    <= STAT_OK;
                        state_ff <= S_Q_DA;
                     end
                  end
                  default: begin
                     res_ff   <= '0;
                     st_ff    <= STAT_OK;
                     state_ff <= S_OUT;
                  end
               endcase
            end
            S_A_DEP: begin
               state_ff <= (LEVELS > 1) ? S_A_RD : S_OUT;
            end
            S_A_RD: state_ff <= S_A_WR;
            S_A_WR: begin
               cur_ff <= anc_q;
               if (lv_ff == TOP_LV) begin
                  state_ff <= S_OUT;
               end else begin
                  lv_ff    <= lv_ff + 1'b1;
                  state_ff <= S_A_RD;
               end
            end
            S_Q_DA: begin
               da_ff    <= dep_q;
               state_ff <= S_Q_DB;
            end
            S_Q_DB: begin
               if (dep_q < da_ff) begin
                  a_ff  <= b_ff;
                  b_ff  <= a_ff;
                  da_ff <= dep_q;
                  db_ff <= da_ff;
               end else begin
                  db_ff <= dep_q;
               end
               lv_ff    <= TOP_LV;
               state_ff <= S_L_TST;
            end
            S_L_TST: begin
               if (step_ok) begin
                  db_ff    <= NODE_W'(CW'(db_ff) - (CW'(1) << lv_ff));
                  state_ff <= S_L_UP;
               end else if (lv_ff == '0) begin
                  state_ff <= S_L_EQ;
               end else begin
                  lv_ff <= lv_ff - 1'b1;
               end
            end
            S_L_UP: begin
               b_ff <= anc_q;
               if (lv_ff == '0) begin
                  state_ff <= S_L_EQ;
               end else begin
                  lv_ff    <= lv_ff - 1'b1;
                  state_ff <= S_L_TST;
               end
            end
            S_L_EQ: begin
               if (a_ff == b_ff) begin
                  tgt_ff   <= a_ff;
                  state_ff <= S_V_RD;
               end else begin
                  lv_ff    <= TOP_LV;
                  state_ff <= S_L2_RD;
               end
            end
            S_L2_RD: state_ff <= S_L2_A;
            S_L2_A: begin
               ta_ff    <= anc_q;
               state_ff <= S_L2_B;
            end
            S_L2_B: begin
               if (ta_ff != anc_q) begin
                  a_ff <= ta_ff;
                  b_ff <= anc_q;
               end
               if (lv_ff == '0) begin
                  state_ff <= S_L2_F;
               end else begin
                  lv_ff    <= lv_ff - 1'b1;
                  state_ff <= S_L2_RD;
               end
            end
            S_L2_F: begin
               tgt_ff   <= anc_q;
               state_ff <= S_V_RD;
            end
            S_V_RD: state_ff <= S_V_CHK;
            S_V_CHK: begin
               if (dead_q) begin
                  tgt_ff   <= alive_rdata;
                  state_ff <= S_V_RD;
               end else begin
                  res_ff   <= tgt_ff;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.result_node <= res_ff;
                  rsp_ff.status      <= st_ff;
                  rsp_valid_ff       <= 1'b1;
                  state_ff           <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   lcaa_ram #(.WIDTH(NODE_W), .DEPTH(NODES * (2 ** LVW))) u_anc_ram (
      .clock(clock), .wr_en(anc_we), .wr_addr({anc_wn, anc_wl}), .wr_data(anc_wd),
      .rd_addr({anc_rn, anc_rl}), .rd_data(anc_rdata)
   );

   lcaa_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_dep_ram (
      .clock(clock), .wr_en(dep_we), .wr_addr(dep_wa), .wr_data(dep_wd),
      .rd_addr(dep_ra), .rd_data(dep_rdata)
   );

   lcaa_ram #(.WIDTH(1), .DEPTH(NODES)) u_dead_ram (
      .clock(clock), .wr_en(dead_we), .wr_addr(dead_wa), .wr_data(dead_wd),
      .rd_addr(dead_ra), .rd_data(dead_rdata)
   );

   lcaa_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_alive_ram (
      .clock(clock), .wr_en(alive_we), .wr_addr(alive_wa), .wr_data(alive_wd),
      .rd_addr(alive_ra), .rd_data(alive_rdata)
   );

endmodule

### sv/lca_alive_ancestor_engine.sv
`timescale 1ns / 1ps
// Top level: lowest living common ancestor engine with a queued front end.
// Kill, refused and empty commands go straight to the response; an add writes the depth
// and each ancestor level of the new node; a query lifts the deeper node, climbs both
// together and follows the alive pointers past each dead node. One ancestor read port
// serves one transaction at a time; a two-entry queue accepts requests while it has room.
// Reset leaves only the root, alive, at depth one; no clearing pass is needed.
module lca_alive_ancestor_engine
   import lcaa_pkg::*;
#(
   parameter int NODES  = 1024,
   parameter int LEVELS = 10
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      q_valid;
   logic      q_pop;
   entry_type q_head;

   lcaa_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
   );

   lcaa_back #(.NODES(NODES), .LEVELS(LEVELS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

### tb/tb_lca_alive_ancestor_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lowest living common ancestor engine.
module tb_lca_alive_ancestor_engine;
   import lcaa_pkg::*;

   localparam int NODE_LIMIT  = 1024;
   localparam int LEVEL_COUNT = 10;

   typedef struct {
      req_type req;
      bit      has_exp;
      rsp_type exp;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int      errors = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      hold_count = 0;
   int      hold_req = 0;
   int      hold_seen = 0;
   rsp_type answer_q[$];

   int unsigned tree_size;
   logic [NODE_W-1:0] jump_table [NODE_LIMIT][LEVEL_COUNT];
   logic [NODE_W-1:0] level_of [NODE_LIMIT];
   bit                is_dead [NODE_LIMIT];
   logic [NODE_W-1:0] alive_link [NODE_LIMIT];

   lca_alive_ancestor_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit known_node(logic [NODE_W-1:0] n);
      return n >= 1 && n <= tree_size;
   endfunction

   function automatic logic [NODE_W-1:0] meeting_node(logic [NODE_W-1:0] a,
                                                      logic [NODE_W-1:0] b);
      logic [NODE_W-1:0] t;
      int lv;
      if (level_of[b] < level_of[a]) begin
         t = a;
         a = b;
         b = t;
      end
      for (lv = LEVEL_COUNT - 1; lv >= 0; lv--) begin
         if (int'(level_of[b]) >= (1 << lv) + int'(level_of[a])) b = jump_table[b][lv];
      end
      if (a == b) return a;
      for (lv = LEVEL_COUNT - 1; lv >= 0; lv--) begin
         if (jump_table[a][lv] != jump_table[b][lv]) begin
            a = jump_table[a][lv];
            b = jump_table[b][lv];
         end
      end
      return jump_table[a][0];
   endfunction

   function automatic logic [NODE_W-1:0] nearest_alive(logic [NODE_W-1:0] v);
      logic [NODE_W-1:0] target;
      logic [NODE_W-1:0] cur;
      logic [NODE_W-1:0] nxt;
      int guard;
      target = v;
      guard = 0;
      while (is_dead[target] && guard < NODE_LIMIT) begin
         target = alive_link[target];
         guard++;
      end
      cur = v;
      guard = 0;
      while (is_dead[cur] && cur != target && guard < NODE_LIMIT) begin
         nxt = alive_link[cur];
         alive_link[cur] = target;
         cur = nxt;
         guard++;
      end
      return target;
   endfunction

   function automatic rsp_type predict_living_lca(req_type r);
      rsp_type o;
      int n;
      int lv;
      o = '0;
      o.status = STAT_OK;
      case (r.command)
         CMD_ADD: begin
            if (!known_node(r.first_node)) begin
               o.status = STAT_UNKNOWN;
            end else if (tree_size + 1 >= NODE_LIMIT) begin
               o.status = STAT_FULL;
            end else begin
               n = tree_size + 1;
               tree_size = n;
               jump_table[n][0] = r.first_node;
               for (lv = 1; lv < LEVEL_COUNT; lv++)
                  jump_table[n][lv] = jump_table[jump_table[n][lv-1]][lv-1];
               alive_link[n] = r.first_node;
               is_dead[n] = 1'b0;
               level_of[n] = level_of[r.first_node] + 1'b1;
               o.result_node = n[NODE_W-1:0];
            end
         end
         CMD_KILL: begin
            if (!known_node(r.first_node) || r.first_node == ROOT_NODE)
               o.status = STAT_UNKNOWN;
            else
               is_dead[r.first_node] = 1'b1;
         end
         CMD_QUERY: begin
            if (!known_node(r.first_node) || !known_node(r.second_node))
               o.status = STAT_UNKNOWN;
            else
               o.result_node = nearest_alive(meeting_node(r.first_node, r.second_node));
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_transaction(req_type r, bit has_exp, rsp_type exp);
      rsp_type p;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_living_lca(r);
      answer_q.push_back(has_exp ? exp : p);
   endtask

   function automatic logic [NODE_W-1:0] pick_node();
      int k;
      k = $urandom_range(99);
      if (k < 4) return '0;
      if (k < 12) return NODE_W'($urandom_range(1023));
      return NODE_W'($urandom_range(1, tree_size));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int k;
      k = $urandom_range(99);
      r.second_node = NODE_W'($urandom_range(1023));
      r.first_node  = pick_node();
      if (k < 42) begin
         r.command = CMD_ADD;
         k = $urandom_range(99);
         if (k < 35) r.first_node = tree_size[NODE_W-1:0];
         else if (k < 55) r.first_node = tree_size > 8 ?
                                         NODE_W'($urandom_range(tree_size - 8, tree_size))
                                         : tree_size[NODE_W-1:0];
      end else if (k < 60) begin
         r.command = CMD_KILL;
      end else if (k < 95) begin
         r.command = CMD_QUERY;
         r.second_node = pick_node();
      end else begin
         r.command = CMD_NOP;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_count <= 400;
         rsp_ready  <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (answer_q.size() == 0) begin
            $error("unexpected result: result_node %0d status %0d",
                   rsp_data.result_node, rsp_data.status);
            errors++;
         end else begin
            e = answer_q.pop_front();
            if (rsp_data.result_node !== e.result_node) begin
               $error("result_node: expected %0d, got %0d", e.result_node,
                      rsp_data.result_node);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               errors++;
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      req_type r;
      int i;
      tree_size = 1;
      for (i = 0; i < NODE_LIMIT; i++) begin
         is_dead[i] = 1'b0;
         level_of[i] = '0;
         alive_link[i] = '0;
      end
      for (i = 0; i < LEVEL_COUNT; i++) jump_table[1][i] = ROOT_NODE;
      level_of[1] = 10'd1;
      alive_link[1] = ROOT_NODE;

      rows = '{
         '{'{CMD_QUERY, 10'd1, 10'd1},       1, '{10'd1, STAT_OK}},
         '{'{CMD_ADD, 10'd0, 10'd1023},      1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_ADD, 10'd2, 10'd0},         1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_KILL, ROOT_NODE, 10'd0},    1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_KILL, 10'd0, 10'd0},        1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_QUERY, 10'd1, 10'd1023},    1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_QUERY, 10'd0, 10'd1},       1, '{10'd0, STAT_UNKNOWN}},
         '{'{CMD_NOP, 10'd1023, 10'd1023},   1, '{10'd0, STAT_OK}},
         '{'{CMD_ADD, 10'd1, 10'd0},         1, '{10'd2, STAT_OK}},
         '{'{CMD_ADD, 10'd2, 10'd0},         1, '{10'd3, STAT_OK}},
         '{'{CMD_ADD, 10'd2, 10'd1023},      1, '{10'd4, STAT_OK}},
         '{'{CMD_ADD, 10'd3, 10'd0},         1, '{10'd5, STAT_OK}},
         '{'{CMD_QUERY, 10'd5, 10'd4},       0, '{10'd0, STAT_OK}},
         '{'{CMD_KILL, 10'd2, 10'd0},        1, '{10'd0, STAT_OK}},
         '{'{CMD_KILL, 10'd2, 10'd0},        1, '{10'd0, STAT_OK}},
         '{'{CMD_QUERY, 10'd5, 10'd4},       1, '{10'd1, STAT_OK}},
         '{'{CMD_KILL, 10'd3, 10'd0},        1, '{10'd0, STAT_OK}},
         '{'{CMD_QUERY, 10'd5, 10'd5},       0, '{10'd0, STAT_OK}},
         '{'{CMD_QUERY, 10'd4, 10'd3},       0, '{10'd0, STAT_OK}},
         '{'{CMD_KILL, 10'd1023, 10'd1023},  1, '{10'd0, STAT_UNKNOWN}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[k]) send_transaction(rows[k].req, rows[k].has_exp, rows[k].exp);

      for (i = 0; i < 800; i++) begin
         case ((i / 100) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 19; stall_pct = 19; end
         endcase
         if (i == 50) hold_req <= hold_req + 1;
         send_transaction(random_request(), 0, '0);
      end

      // Grow the tree until it is full, then keep hitting the full table.
      idle_pct = 10;
      stall_pct = 10;
      while (tree_size + 1 < NODE_LIMIT) begin
         r.command = CMD_ADD;
         r.first_node = ($urandom_range(1) == 0) ? tree_size[NODE_W-1:0]
                                                 : NODE_W'($urandom_range(1, tree_size));
         r.second_node = NODE_W'($urandom_range(1023));
         send_transaction(r, 0, '0);
      end
      for (i = 0; i < 60; i++) send_transaction(random_request(), 0, '0);
      r = '{CMD_QUERY, 10'd1023, 10'd1023};
      send_transaction(r, 0, '0);
      r = '{CMD_ADD, 10'd1023, 10'd0};
      send_transaction(r, 1, '{10'd0, STAT_FULL});

      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb_lca_alive_ancestor_engine: clean");
      else
         $display("tb_lca_alive_ancestor_engine: errors");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb_lca_alive_ancestor_engine: errors");
      $finish;
   end

endmodule

### files.f
sv/lcaa_pkg.sv
sv/lcaa_ram.sv
sv/lcaa_front.sv
sv/lcaa_back.sv
sv/lca_alive_ancestor_engine.sv
tb/tb_lca_alive_ancestor_engine.sv
